FILE: hdl/icalc_pkg.sv
// Shared constants, operation codes, beat and unit types for the integer calculator ALU.
package icalc_pkg;

   localparam int DATA_WIDTH = 32;
   // factorial wraps to zero from this argument on
   localparam int FACT_LIMIT = 2 * DATA_WIDTH;
   localparam int CNT_WIDTH  = $clog2(FACT_LIMIT + 1);

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_REM  = 3'd4,
      OP_POW  = 3'd5,
      OP_FACT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DIV_FIX,
      ST_POW_ACC,
      ST_POW_SQ,
      ST_FACT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]                   op;
      logic signed [DATA_WIDTH-1:0] lower_operand;
      logic signed [DATA_WIDTH-1:0] top_operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic                         status;
   } rsp_type;

   // operands presented to the shared unit
   typedef struct packed {
      logic [DATA_WIDTH-1:0] mul_x;
      logic [DATA_WIDTH-1:0] mul_y;
      logic [DATA_WIDTH-1:0] div_rem;
      logic [DATA_WIDTH-1:0] div_quo;
      logic [DATA_WIDTH-1:0] div_dvs;
   } unit_cmd_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] prod;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
   } unit_res_type;

endpackage

FILE: hdl/integer_calculator_alu.sv
// Integer calculator ALU top level: sequencer, operand registers and result register.
//
// One request beat at a time. Add, subtract and all trivial cases (divide by zero,
// exponent not positive, factorial out of range, unused code) go from accept straight
// to the hand-over state. Multiply passes through the multiply state. Divide and
// remainder produce one quotient bit per cycle in the restoring divide step, then fix
// the signs. Power alternates an accumulate and a square state per exponent bit up to
// the highest set bit, since the square and the accumulate share one multiplier.
// Factorial of n multiplies in 2 up to n, one multiply per cycle. req_stall is high
// from accept until the result enters the output register; a finished result waits
// there without holding off the next request.
module integer_calculator_alu (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  icalc_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output icalc_pkg::rsp_type  rsp_payload
);

   localparam int W  = icalc_pkg::DATA_WIDTH;
   localparam int CW = icalc_pkg::CNT_WIDTH;

   icalc_pkg::state_type state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [W-1:0]         opa_ff, opa_in;
   logic [W-1:0]         opb_ff, opb_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 neg_q_ff, neg_q_in;
   logic                 neg_r_ff, neg_r_in;
   logic                 status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   icalc_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;

   icalc_pkg::unit_cmd_type unit_cmd;
   icalc_pkg::unit_res_type unit_res;

   logic         accept;
   logic [W-1:0] a_in;
   logic [W-1:0] b_in;
   logic [W-1:0] a_mag;
   logic [W-1:0] b_mag;

   icalc_unit u_unit (
      .cmd (unit_cmd),
      .res (unit_res)
   );

   assign req_stall   = (state_ff != icalc_pkg::ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign a_in  = req_payload.lower_operand;
   assign b_in  = req_payload.top_operand;
   assign a_mag = a_in[W-1] ? (~a_in + W'(1)) : a_in;
   assign b_mag = b_in[W-1] ? (~b_in + W'(1)) : b_in;

   // operand steering for the shared unit
   always_comb begin
      unit_cmd.div_rem = acc_ff;
      unit_cmd.div_quo = opa_ff;
      unit_cmd.div_dvs = opb_ff;
      case (state_ff)
         icalc_pkg::ST_POW_ACC: begin
            unit_cmd.mul_x = acc_ff;
            unit_cmd.mul_y = opa_ff;
         end
         icalc_pkg::ST_POW_SQ: begin
            unit_cmd.mul_x = opa_ff;
            unit_cmd.mul_y = opa_ff;
         end
         icalc_pkg::ST_FACT: begin
            unit_cmd.mul_x = acc_ff;
            unit_cmd.mul_y = {{(W-CW){1'b0}}, cnt_ff};
         end
         default: begin
            unit_cmd.mul_x = opa_ff;
            unit_cmd.mul_y = opb_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= icalc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      opa_ff         <= opa_in;
      opb_ff         <= opb_in;
      acc_ff         <= acc_in;
      cnt_ff         <= cnt_in;
      neg_q_ff       <= neg_q_in;
      neg_r_ff       <= neg_r_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      neg_q_in       = neg_q_ff;
      neg_r_in       = neg_r_ff;
      status_in      = status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         icalc_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = req_payload.op;
               status_in = 1'b0;
               acc_in    = '0;
               state_in  = icalc_pkg::ST_DONE;
               case (req_payload.op)
                  icalc_pkg::OP_ADD: acc_in = a_in + b_in;
                  icalc_pkg::OP_SUB: acc_in = a_in - b_in;
                  icalc_pkg::OP_MUL: begin
                     opa_in   = a_in;
                     opb_in   = b_in;
                     state_in = icalc_pkg::ST_MUL;
                  end
                  icalc_pkg::OP_DIV, icalc_pkg::OP_REM: begin
                     if (b_in == '0) begin
                        status_in = 1'b1;
                     end else begin
                        opa_in   = a_mag;
                        opb_in   = b_mag;
                        cnt_in   = '0;
                        neg_q_in = a_in[W-1] ^ b_in[W-1];
                        neg_r_in = a_in[W-1];
                        state_in = icalc_pkg::ST_DIV;
                     end
                  end
                  icalc_pkg::OP_POW: begin
                     acc_in = W'(1);
                     if (!b_in[W-1] && b_in != '0) begin
                        opa_in   = a_in;
                        opb_in   = b_in;
                        state_in = icalc_pkg::ST_POW_ACC;
                     end
                  end
                  icalc_pkg::OP_FACT: begin
                     if (!b_in[W-1] && b_in < W'(icalc_pkg::FACT_LIMIT)) begin
                        acc_in   = W'(1);
                        opb_in   = b_in;
                        cnt_in   = CW'(2);
                        state_in = icalc_pkg::ST_FACT;
                     end
                  end
                  default: acc_in = '0;
               endcase
            end
         end
         icalc_pkg::ST_MUL: begin
            acc_in   = unit_res.prod;
            state_in = icalc_pkg::ST_DONE;
         end
         icalc_pkg::ST_DIV: begin
            acc_in = unit_res.rem;
            opa_in = unit_res.quo;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               state_in = icalc_pkg::ST_DIV_FIX;
            end
         end
         icalc_pkg::ST_DIV_FIX: begin
            // restore signs: quotient by xor of signs, remainder follows dividend
            if (op_ff == icalc_pkg::OP_DIV) begin
               acc_in = neg_q_ff ? (~opa_ff + W'(1)) : opa_ff;
            end else begin
               acc_in = neg_r_ff ? (~acc_ff + W'(1)) : acc_ff;
            end
            state_in = icalc_pkg::ST_DONE;
         end
         icalc_pkg::ST_POW_ACC: begin
            if (opb_ff[0]) begin
               acc_in = unit_res.prod;
            end
            state_in = icalc_pkg::ST_POW_SQ;
         end
         icalc_pkg::ST_POW_SQ: begin
            opa_in = unit_res.prod;
            opb_in = opb_ff >> 1;
            if ((opb_ff >> 1) == '0) begin
               state_in = icalc_pkg::ST_DONE;
            end else begin
               state_in = icalc_pkg::ST_POW_ACC;
            end
         end
         icalc_pkg::ST_FACT: begin
            if (cnt_ff > opb_ff[CW-1:0]) begin
               state_in = icalc_pkg::ST_DONE;
            end else begin
               acc_in = unit_res.prod;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         icalc_pkg::ST_DONE: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_payload_in.result = acc_ff;
               rsp_payload_in.status = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = icalc_pkg::ST_IDLE;
            end
         end
         default: state_in = icalc_pkg::ST_IDLE;
      endcase
   end

   // an accepted beat keeps the request side stalled on the next cycle
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after accept");

   // a divide-by-zero beat carries a zero result
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status) |-> (rsp_payload.result == '0))
      else $error("error beat with nonzero result");

   // a new result only appears out of the hand-over state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == icalc_pkg::ST_DONE))
      else $error("result beat without hand-over");

   // a waiting result is not overwritten while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result beat changed");

endmodule

FILE: hdl/icalc_unit.sv
// Shared arithmetic unit: wrapped multiplier and one restoring divide step.
module icalc_unit (
   input  icalc_pkg::unit_cmd_type cmd,
   output icalc_pkg::unit_res_type res
);

   localparam int W = icalc_pkg::DATA_WIDTH;

   logic [2*W-1:0] full_prod;
   logic [W:0]     shifted;
   logic [W:0]     trial;
   logic           ge;

   assign full_prod = cmd.mul_x * cmd.mul_y;

   // bring down the next dividend bit, subtract when it fits
   assign shifted = {cmd.div_rem, cmd.div_quo[W-1]};
   assign ge      = shifted >= {1'b0, cmd.div_dvs};
   assign trial   = shifted - {1'b0, cmd.div_dvs};

   always_comb begin
      res.prod = full_prod[W-1:0];
      res.rem  = ge ? trial[W-1:0] : shifted[W-1:0];
      res.quo  = {cmd.div_quo[W-2:0], ge};
   end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the integer calculator ALU: random and corner commands.
`timescale 1ns / 100ps

module tb;

   localparam int W = icalc_pkg::DATA_WIDTH;
   localparam logic [2:0] OP_SPARE = 3'd7;
   localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 80;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      icalc_pkg::req_type cmd;
      icalc_pkg::rsp_type ans;
   } answer_entry_type;

   class calc_scoreboard_type;
      answer_entry_type answer_q[$];
      int mismatches = 0;

      function icalc_pkg::rsp_type compute_answer(icalc_pkg::req_type c);
         logic [W-1:0] a, b, ua, ub, q, r, acc, sq, e;
         int k;
         icalc_pkg::rsp_type ans;
         a = c.lower_operand;
         b = c.top_operand;
         ans.result = '0;
         ans.status = 1'b0;
         case (c.op)
            icalc_pkg::OP_ADD: ans.result = a + b;
            icalc_pkg::OP_SUB: ans.result = a - b;
            icalc_pkg::OP_MUL: ans.result = a * b;
            icalc_pkg::OP_DIV, icalc_pkg::OP_REM: begin
               if (b == '0) begin
                  ans.status = 1'b1;
               end else begin
                  ua = a[W-1] ? -a : a;
                  ub = b[W-1] ? -b : b;
                  q = ua / ub;
                  r = ua % ub;
                  if (c.op == icalc_pkg::OP_DIV)
                     ans.result = (a[W-1] != b[W-1]) ? -q : q;
                  else
                     ans.result = a[W-1] ? -r : r;
               end
            end
            icalc_pkg::OP_POW: begin
               acc = 1;
               if (!b[W-1] && b != '0) begin
                  sq = a;
                  e = b;
                  while (e != '0) begin
                     if (e[0])
                        acc = acc * sq;
                     sq = sq * sq;
                     e = e >> 1;
                  end
               end
               ans.result = acc;
            end
            icalc_pkg::OP_FACT: begin
               acc = 1;
               // negative or at least 2*W wraps to zero
               if (b[W-1] || b >= icalc_pkg::FACT_LIMIT) begin
                  acc = '0;
               end else begin
                  for (k = 2; k <= b; k++)
                     acc = acc * k;
               end
               ans.result = acc;
            end
            default: ans.result = '0;
         endcase
         return ans;
      endfunction

      function void note_command(icalc_pkg::req_type c);
         answer_entry_type entry;
         entry.cmd = c;
         entry.ans = compute_answer(c);
         answer_q.push_back(entry);
      endfunction

      function void check_answer(icalc_pkg::rsp_type got);
         answer_entry_type entry;
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result beat: result %0d status %0b",
                        got.result, got.status);
            return;
         end
         entry = answer_q.pop_front();
         if (got.result !== entry.ans.result || got.status !== entry.ans.status) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch op %0d a %0d b %0d: exp %0d/%0b got %0d/%0b",
                        entry.cmd.op, entry.cmd.lower_operand, entry.cmd.top_operand,
                        entry.ans.result, entry.ans.status, got.result, got.status);
         end
      endfunction

      function int waiting();
         return answer_q.size();
      endfunction

      function bit clean();
         return mismatches == 0 && answer_q.size() == 0;
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   icalc_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   icalc_pkg::rsp_type rsp_payload;

   calc_scoreboard_type board;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   integer_calculator_alu dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall, or a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_answer(rsp_payload);
   end

   task automatic send_command(icalc_pkg::req_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = c;
      do
         @(posedge clock);
      while (req_stall);
      board.note_command(c);
      @(negedge clock);
   endtask

   task automatic send_op(logic [2:0] op, logic signed [W-1:0] a, logic signed [W-1:0] b);
      icalc_pkg::req_type c;
      c.op = op;
      c.lower_operand = a;
      c.top_operand = b;
      send_command(c);
   endtask

   task automatic wait_for_answers();
      req_valid = 1'b0;
      while (board.waiting() != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [W-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3: return -1;
         4: return 1;
         5, 6: return int'($urandom_range(0, 64)) - 32;
         7: return $urandom & 32'hFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(int count);
      icalc_pkg::req_type c;
      repeat (count) begin
         c.op = 3'($urandom_range(0, 7));
         c.lower_operand = pick_operand();
         c.top_operand = pick_operand();
         // keep factorial arguments mostly in the interesting range
         if (c.op == icalc_pkg::OP_FACT && $urandom_range(0, 3) != 0)
            c.top_operand = $urandom_range(0, 70);
         if (c.op == icalc_pkg::OP_POW && $urandom_range(0, 1) == 0)
            c.top_operand = int'($urandom_range(0, 40)) - 5;
         send_command(c);
      end
   endtask

   task automatic run_directed();
      send_op(icalc_pkg::OP_ADD, MOST_POS, 1);
      send_op(icalc_pkg::OP_ADD, MOST_NEG, MOST_NEG);
      send_op(icalc_pkg::OP_SUB, MOST_NEG, 1);
      send_op(icalc_pkg::OP_MUL, MOST_POS, MOST_POS);
      send_op(icalc_pkg::OP_MUL, MOST_NEG, -1);
      send_op(icalc_pkg::OP_DIV, 7, -2);
      send_op(icalc_pkg::OP_DIV, -7, 2);
      send_op(icalc_pkg::OP_DIV, MOST_POS, 0);
      send_op(icalc_pkg::OP_REM, MOST_NEG, 0);
      send_op(icalc_pkg::OP_DIV, MOST_NEG, -1);
      send_op(icalc_pkg::OP_REM, MOST_NEG, -1);
      send_op(icalc_pkg::OP_REM, -7, 2);
      send_op(icalc_pkg::OP_REM, 7, -2);
      send_op(icalc_pkg::OP_POW, 0, 0);
      send_op(icalc_pkg::OP_POW, 2, -1);
      send_op(icalc_pkg::OP_POW, 3, MOST_POS);
      send_op(icalc_pkg::OP_POW, -1, 3);
      send_op(icalc_pkg::OP_POW, 2, 31);
      send_op(icalc_pkg::OP_FACT, MOST_POS, -1);
      send_op(icalc_pkg::OP_FACT, 0, 0);
      send_op(icalc_pkg::OP_FACT, MOST_NEG, 1);
      send_op(icalc_pkg::OP_FACT, 5, 12);
      send_op(icalc_pkg::OP_FACT, 0, icalc_pkg::FACT_LIMIT - 1);
      send_op(icalc_pkg::OP_FACT, 0, icalc_pkg::FACT_LIMIT);
      send_op(OP_SPARE, MOST_NEG, MOST_POS);
   endtask

   initial begin
      board = new;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 84;
      run_directed();
      run_random(340);
      wait_for_answers();

      send_idle_pct = 84;
      recv_idle_pct = 17;
      run_random(330);
      wait_for_answers();

      // sender keeps offering while the result side holds off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      run_random(330);
      wait_for_answers();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.clean())
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/icalc_pkg.sv
hdl/icalc_unit.sv
hdl/integer_calculator_alu.sv
bench/tb.sv
